[design/spr_pkg.sv]
// Shared types, constants and table defaults for the servo packet responder
package spr_pkg;

  localparam int MAX_PARAMS    = 64;
  localparam int PERSIST_BYTES = 24;
  localparam int RAM_BYTES     = 26;
  localparam int TABLE_BYTES   = PERSIST_BYTES + RAM_BYTES;
  localparam int TBL_AW        = 6;
  localparam int PRM_AW        = $clog2(MAX_PARAMS);
  localparam int SEQ_W         = (PRM_AW > TBL_AW) ? PRM_AW : TBL_AW;
  localparam int LEN_OVH       = 2;
  localparam int WR_OVH        = 3;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [7:0] BCAST_ID     = 8'hFE;
  localparam logic [7:0] MIN_WR_START = 8'd3;
  localparam logic [7:0] STATUS_ERR   = 8'h00;

  localparam logic [TBL_AW-1:0] ID_ADDR     = 6'd3;
  localparam logic [TBL_AW-1:0] BAUD_ADDR   = 6'd4;
  localparam logic [TBL_AW-1:0] TORQUE_ADDR = 6'(PERSIST_BYTES);
  localparam logic [TBL_AW-1:0] LOCK_ADDR   = 6'(PERSIST_BYTES + 23);

  localparam logic [7:0] INS_PING      = 8'h01;
  localparam logic [7:0] INS_READ      = 8'h02;
  localparam logic [7:0] INS_WRITE     = 8'h03;
  localparam logic [7:0] INS_REG_WRITE = 8'h04;
  localparam logic [7:0] INS_ACTION    = 8'h05;
  localparam logic [7:0] INS_RESET     = 8'h06;

  localparam logic [1:0] CMD_RX  = 2'd0;
  localparam logic [1:0] CMD_LWR = 2'd1;
  localparam logic [1:0] CMD_LRD = 2'd2;

  localparam logic [1:0] CFG_ID     = 2'd0;
  localparam logic [1:0] CFG_BAUD   = 2'd1;
  localparam logic [1:0] CFG_TORQUE = 2'd2;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_LOCAL = 1'b1;

  localparam logic [7:0] PERSIST_DFLT [PERSIST_BYTES] = '{
    8'h0C, 8'h00, 8'h2A, 8'h01, 8'h01, 8'hFA, 8'h00, 8'h00, 8'hFF, 8'h03, 8'h00, 8'h55,
    8'h3C, 8'hBE, 8'hFF, 8'h03, 8'h02, 8'h04, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] RAM_DFLT [RAM_BYTES] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h03,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h20, 8'h00};

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic [5:0] local_addr;
    logic [7:0] local_data;
  } in_item_t;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [2:0] {
    RS_LOCAL, RS_ID, RS_LOCK, RS_SEQ, RS_SEQ_NEXT
  } tbl_rsel_t;

  typedef enum logic [1:0] {
    PS_0, PS_1, PS_SEQ
  } prm_rsel_t;

  typedef enum logic [2:0] {
    OB_FF, OB_TBL, OB_LEN, OB_ERR, OB_CHK, OB_LOCAL
  } obyte_sel_t;

  typedef enum logic [1:0] {
    LD_NONE, LD_READ, LD_WRITE, LD_ZERO
  } seq_ld_t;

  typedef struct packed {
    logic       parse;
    logic       lwrite;
    tbl_rsel_t  tbl_rsel;
    prm_rsel_t  prm_rsel;
    logic       cap_id;
    logic       cap_p0;
    logic       cap_lock;
    logic       cap_p1;
    logic       restore;
    seq_ld_t    seq_ld;
    logic       idx_inc;
    logic       seq_wr;
    logic       emit;
    obyte_sel_t osel;
    logic       olast;
  } dp_cmd_t;

  typedef struct packed {
    logic       exec_go;
    logic       bcast;
    logic       own_match;
    logic [7:0] instr;
    logic       rd_ok;
    logic       wr_start_ok;
    logic       wr_range_ok;
    logic       seq_empty;
    logic       seq_done;
    logic       seq_last;
  } dp_sts_t;

  // Value of a table byte that has not been written since the last restore
  function automatic logic [7:0] tbl_default(input logic [TBL_AW-1:0] a,
                                             input logic [7:0] id,
                                             input logic [7:0] baud,
                                             input logic tq);
    logic [7:0] b;
    b = 8'h00;
    if (a == ID_ADDR) begin
      b = id;
    end else if (a == BAUD_ADDR) begin
      b = baud;
    end else if (a == TORQUE_ADDR) begin
      b = {7'd0, tq};
    end else if (a < TORQUE_ADDR) begin
      b = PERSIST_DFLT[a[4:0]];
    end else if (a < TBL_AW'(TABLE_BYTES)) begin
      b = RAM_DFLT[5'(a - TORQUE_ADDR)];
    end
    return b;
  endfunction

endpackage

[design/spr_dp.sv]
// Datapath: packet parser, parameter store, control table and reply byte path
module spr_dp
  import spr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_item,
  input  logic       cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output logic       cfg_ready,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic       out_strobe,
  output out_item_t  out_item
);

  typedef enum logic [2:0] {
    PH_START1, PH_START2, PH_ID, PH_LENGTH, PH_INSTR, PH_PARAM, PH_CHECK
  } phase_t;

  phase_t      phase_r;
  logic [7:0]  pid_r, len_r, instr_r, rsum_r, cnt_r;
  logic        exec_go_r;
  logic [7:0]  b;

  logic [7:0]  cfg_id_r, cfg_baud_r, dflt_id_r, dflt_baud_r;
  logic        cfg_tq_r, dflt_tq_r;

  logic [7:0]  prm_mem [MAX_PARAMS];
  logic [PRM_AW-1:0] prm_ra;
  logic [7:0]  prm_rdata_r;

  logic [7:0]  tbl_mem [TABLE_BYTES];
  logic [TABLE_BYTES-1:0] tbl_vld_r;
  logic [TBL_AW-1:0] tbl_ra, tbl_ra_r, tbl_wa;
  logic [7:0]  tbl_md_r, tbl_wd, tbl_rdata;
  logic        tbl_hit_r, tbl_we;

  logic [7:0]  own_id_r, p0_r, p1_r, lock_r, wlen;
  logic [SEQ_W-1:0] start_r, n_r, idx_r;
  logic [TBL_AW-1:0] seq_addr, seq_next;
  logic [7:0]  sum_r, obyte;
  logic        out_strobe_r;
  out_item_t   out_item_r;

  assign b = in_item.rx_byte;
  assign cfg_ready = 1'b1;

  // Packet deframing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START1;
      pid_r     <= '0;
      len_r     <= '0;
      instr_r   <= '0;
      rsum_r    <= '0;
      cnt_r     <= '0;
      exec_go_r <= 1'b0;
    end else if (cmd.parse) begin
      exec_go_r <= 1'b0;
      unique case (phase_r)
        PH_START1: begin
          if (b == SYNC_BYTE) phase_r <= PH_START2;
        end
        PH_START2: begin
          if (b == SYNC_BYTE) begin
            phase_r <= PH_ID;
            rsum_r  <= '0;
          end else begin
            phase_r <= PH_START1;
          end
        end
        PH_ID: begin
          pid_r   <= b;
          rsum_r  <= rsum_r + b;
          phase_r <= PH_LENGTH;
        end
        PH_LENGTH: begin
          len_r   <= b;
          rsum_r  <= rsum_r + b;
          phase_r <= PH_INSTR;
        end
        PH_INSTR: begin
          instr_r <= b;
          rsum_r  <= rsum_r + b;
          cnt_r   <= '0;
          phase_r <= (len_r <= 8'(LEN_OVH)) ? PH_CHECK : PH_PARAM;
        end
        PH_PARAM: begin
          cnt_r  <= cnt_r + 8'd1;
          rsum_r <= rsum_r + b;
          if ({1'b0, len_r} <= 9'(cnt_r) + 9'(LEN_OVH + 1)) phase_r <= PH_CHECK;
        end
        PH_CHECK: begin
          exec_go_r <= (b == ~rsum_r) && ({1'b0, len_r} <= 9'(MAX_PARAMS + LEN_OVH));
          phase_r   <= PH_START1;
        end
        default: phase_r <= PH_START1;
      endcase
    end else begin
      exec_go_r <= 1'b0;
    end
  end

  // Parameter store
  always_comb begin
    unique case (cmd.prm_rsel)
      PS_0:    prm_ra = '0;
      PS_1:    prm_ra = PRM_AW'(1);
      PS_SEQ:  prm_ra = PRM_AW'(idx_r + SEQ_W'(1));
      default: prm_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.parse && phase_r == PH_PARAM && cnt_r < 8'(MAX_PARAMS))
      prm_mem[PRM_AW'(cnt_r)] <= b;
    prm_rdata_r <= prm_mem[prm_ra];
  end

  // Configuration and restore snapshot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_id_r    <= 8'd1;
      cfg_baud_r  <= 8'd1;
      cfg_tq_r    <= 1'b0;
      dflt_id_r   <= 8'd1;
      dflt_baud_r <= 8'd1;
      dflt_tq_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ID:     cfg_id_r   <= cfg_data;
          CFG_BAUD:   cfg_baud_r <= cfg_data;
          CFG_TORQUE: cfg_tq_r   <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.restore) begin
        dflt_id_r   <= cfg_id_r;
        dflt_baud_r <= cfg_baud_r;
        dflt_tq_r   <= cfg_tq_r;
      end
    end
  end

  // Control table
  assign seq_addr = TBL_AW'(start_r + idx_r);
  assign seq_next = TBL_AW'(start_r + idx_r + SEQ_W'(1));

  always_comb begin
    unique case (cmd.tbl_rsel)
      RS_LOCAL:    tbl_ra = in_item.local_addr;
      RS_ID:       tbl_ra = ID_ADDR;
      RS_LOCK:     tbl_ra = LOCK_ADDR;
      RS_SEQ:      tbl_ra = seq_addr;
      RS_SEQ_NEXT: tbl_ra = seq_next;
      default:     tbl_ra = ID_ADDR;
    endcase
  end

  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = seq_addr;
    tbl_wd = prm_rdata_r;
    if (cmd.lwrite) begin
      tbl_wa = in_item.local_addr;
      tbl_wd = in_item.local_data;
      tbl_we = in_item.local_addr < TBL_AW'(TABLE_BYTES);
    end else if (cmd.seq_wr) begin
      // persistent bytes stay untouched while locked
      tbl_we = !(lock_r != 8'd0 && seq_addr < TORQUE_ADDR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (cmd.restore) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[tbl_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    tbl_ra_r  <= tbl_ra;
    tbl_hit_r <= (tbl_ra < TBL_AW'(TABLE_BYTES)) && tbl_vld_r[tbl_ra];
    if (tbl_ra < TBL_AW'(TABLE_BYTES)) tbl_md_r <= tbl_mem[tbl_ra];
  end

  assign tbl_rdata = tbl_hit_r ? tbl_md_r
                               : tbl_default(tbl_ra_r, dflt_id_r, dflt_baud_r, dflt_tq_r);

  // Execution operands and byte sequencer
  assign wlen = (len_r >= 8'(WR_OVH)) ? len_r - 8'(WR_OVH) : 8'd0;

  always_ff @(posedge clk) begin
    if (cmd.cap_id)   own_id_r <= tbl_rdata;
    if (cmd.cap_p0)   p0_r     <= prm_rdata_r;
    if (cmd.cap_lock) lock_r   <= tbl_rdata;
    if (cmd.cap_p1)   p1_r     <= prm_rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      n_r     <= '0;
      idx_r   <= '0;
    end else begin
      unique case (cmd.seq_ld)
        LD_READ: begin
          start_r <= SEQ_W'(p0_r);
          n_r     <= SEQ_W'(p1_r);
          idx_r   <= '0;
        end
        LD_WRITE: begin
          start_r <= SEQ_W'(p0_r);
          n_r     <= SEQ_W'(wlen);
          idx_r   <= '0;
        end
        LD_ZERO: begin
          n_r   <= '0;
          idx_r <= '0;
        end
        LD_NONE: begin
          if (cmd.idx_inc) idx_r <= idx_r + SEQ_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.exec_go     = exec_go_r;
    sts.bcast       = pid_r == BCAST_ID;
    sts.own_match   = pid_r == own_id_r;
    sts.instr       = instr_r;
    sts.rd_ok       = ({1'b0, p0_r} + {1'b0, p1_r}) <= 9'(TABLE_BYTES);
    sts.wr_start_ok = p0_r >= MIN_WR_START;
    sts.wr_range_ok = ({1'b0, p0_r} + {1'b0, wlen}) <= 9'(TABLE_BYTES);
    sts.seq_empty   = n_r == '0;
    sts.seq_done    = idx_r == n_r;
    sts.seq_last    = (idx_r + SEQ_W'(1)) == n_r;
  end

  // Reply bytes and checksum
  always_comb begin
    unique case (cmd.osel)
      OB_FF:    obyte = SYNC_BYTE;
      OB_TBL:   obyte = tbl_rdata;
      OB_LEN:   obyte = 8'(n_r) + 8'(LEN_OVH);
      OB_ERR:   obyte = STATUS_ERR;
      OB_CHK:   obyte = ~sum_r;
      OB_LOCAL: obyte = tbl_rdata;
      default:  obyte = STATUS_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.emit) begin
        if (cmd.osel == OB_FF) sum_r <= '0;
        else                   sum_r <= sum_r + obyte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.out_kind <= (cmd.osel == OB_LOCAL) ? KIND_LOCAL : KIND_TX;
      out_item_r.out_byte <= obyte;
      out_item_r.out_last <= cmd.olast;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[design/spr_ctrl.sv]
// Controller: sequences parsing, packet execution, table writes and replies
module spr_ctrl
  import spr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] command,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd,
  output logic       busy
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LRD, ST_PARSED, ST_EXA, ST_EXB, ST_DEC, ST_WRD, ST_WWR,
    ST_FF1, ST_FF2, ST_ID, ST_LEN, ST_ERR, ST_DATA, ST_CHK
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = state_r != ST_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_RX: begin
              cmd.parse = 1'b1;
              state_nxt = ST_PARSED;
            end
            CMD_LWR: cmd.lwrite = 1'b1;
            CMD_LRD: begin
              cmd.tbl_rsel = RS_LOCAL;
              state_nxt    = ST_LRD;
            end
            default: ;
          endcase
        end
      end
      ST_LRD: begin
        cmd.emit  = 1'b1;
        cmd.osel  = OB_LOCAL;
        cmd.olast = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_PARSED: begin
        if (sts.exec_go) begin
          cmd.tbl_rsel = RS_ID;
          cmd.prm_rsel = PS_0;
          state_nxt    = ST_EXA;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EXA: begin
        cmd.cap_id   = 1'b1;
        cmd.cap_p0   = 1'b1;
        cmd.tbl_rsel = RS_LOCK;
        cmd.prm_rsel = PS_1;
        state_nxt    = ST_EXB;
      end
      ST_EXB: begin
        cmd.cap_lock = 1'b1;
        cmd.cap_p1   = 1'b1;
        state_nxt    = ST_DEC;
      end
      ST_DEC: begin
        state_nxt = ST_IDLE;
        if (sts.bcast || sts.own_match) begin
          priority if (sts.instr == INS_PING || sts.instr == INS_ACTION) begin
            if (!sts.bcast) begin
              cmd.seq_ld = LD_ZERO;
              state_nxt  = ST_FF1;
            end
          end else if (sts.instr == INS_READ) begin
            if (!sts.bcast && sts.rd_ok) begin
              cmd.seq_ld = LD_READ;
              state_nxt  = ST_FF1;
            end
          end else if (sts.instr == INS_WRITE || sts.instr == INS_REG_WRITE) begin
            if (sts.wr_start_ok) begin
              if (sts.wr_range_ok) begin
                cmd.seq_ld = LD_WRITE;
                state_nxt  = ST_WRD;
              end else if (!sts.bcast) begin
                cmd.seq_ld = LD_ZERO;
                state_nxt  = ST_FF1;
              end
            end
          end else if (sts.instr == INS_RESET) begin
            cmd.restore = 1'b1;
            if (!sts.bcast) begin
              cmd.seq_ld = LD_ZERO;
              state_nxt  = ST_FF1;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_WRD: begin
        if (sts.seq_done) begin
          if (sts.bcast) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.seq_ld = LD_ZERO;
            state_nxt  = ST_FF1;
          end
        end else begin
          cmd.prm_rsel = PS_SEQ;
          state_nxt    = ST_WWR;
        end
      end
      ST_WWR: begin
        cmd.seq_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = ST_WRD;
      end
      ST_FF1: begin
        cmd.emit     = 1'b1;
        cmd.osel     = OB_FF;
        cmd.tbl_rsel = RS_ID;
        state_nxt    = ST_FF2;
      end
      ST_FF2: begin
        cmd.emit     = 1'b1;
        cmd.osel     = OB_FF;
        cmd.tbl_rsel = RS_ID;
        state_nxt    = ST_ID;
      end
      ST_ID: begin
        cmd.emit  = 1'b1;
        cmd.osel  = OB_TBL;
        state_nxt = ST_LEN;
      end
      ST_LEN: begin
        cmd.emit  = 1'b1;
        cmd.osel  = OB_LEN;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        // prefetch the first data byte
        cmd.emit     = 1'b1;
        cmd.osel     = OB_ERR;
        cmd.tbl_rsel = RS_SEQ;
        state_nxt    = sts.seq_empty ? ST_CHK : ST_DATA;
      end
      ST_DATA: begin
        cmd.emit     = 1'b1;
        cmd.osel     = OB_TBL;
        cmd.idx_inc  = 1'b1;
        cmd.tbl_rsel = RS_SEQ_NEXT;
        state_nxt    = sts.seq_last ? ST_CHK : ST_DATA;
      end
      ST_CHK: begin
        cmd.emit  = 1'b1;
        cmd.osel  = OB_CHK;
        cmd.olast = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[design/servo_packet_responder.sv]
// Top level of the servo packet responder
//
//  Channel   Handshake                  Payload
//  input     start / busy               in_item  (in_item_t)
//  result    out_strobe, one cycle      out_item (out_item_t)
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A local write is taken in idle and leaves busy low. A serial byte, a local read and
// a packet end raise busy. A packet end whose checksum holds is executed: its ID and
// lock bytes and first two parameters are read, its data bytes written one by one, and
// unless broadcast a reply of 6 + n bytes is sent, one byte at a time, for n data bytes.
// Synchronous reset restores the table defaults through per-entry valid bits.
// Results go out once each and cannot be held off.
module servo_packet_responder
  import spr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_strobe,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  spr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (in_item.command),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  spr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
